// ===== rtl/core/cht_pkg.sv =====
package cht_pkg;

  localparam int unsigned FirstDepth  = 8;
  localparam int unsigned SecondDepth = 16;
  localparam int unsigned PathLimit   = 24;

  localparam int unsigned FirstAw  = $clog2(FirstDepth);
  localparam int unsigned SecondAw = $clog2(SecondDepth);
  localparam int unsigned SlotW    = (FirstAw > SecondAw) ? FirstAw : SecondAw;
  localparam int unsigned PathAw   = $clog2(PathLimit);
  localparam int unsigned DepthW   = $clog2(PathLimit + 1);

  localparam logic [1:0] CmdSearch = 2'd0;
  localparam logic [1:0] CmdInsert = 2'd1;
  localparam logic [1:0] CmdRemove = 2'd2;

  localparam logic [2:0] StFound    = 3'd0;
  localparam logic [2:0] StNotFound = 3'd1;
  localparam logic [2:0] StUpdated  = 3'd2;
  localparam logic [2:0] StInserted = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StRemoved  = 3'd5;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

endpackage

// ===== rtl/core/cht_mem.sv =====
module cht_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Aw    = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/cuckoo_hash_table_top.sv =====
// Two-table cuckoo hash table for 32-bit keys and 32-bit signed values.
// Input channel: in_valid_i with in_cmd_i, in_key_i and in_value_i; the block
// raises in_stall_o while it works on an item. Output channel: out_valid_o
// with out_status_o and out_found_value_o; the receiver may hold out_stall_i.
// Exactly one result follows each input transfer, in order.
// A search, update or remove reads both home slots at the transfer edge,
// decides and writes in the next cycle, and offers its result in the cycle
// after that. An insert into an empty home slot also passes through SPlace
// to place the pair before its result is offered.
// An insert that must displace entries walks its path one slot per step,
// SWalkRd then SWalk (one memory read per step), and then shifts the entries
// back, one move per step, SMovRd then SMove, before SPlace places the pair.
// The block takes one item at a time. The result waits in an output register
// while out_stall_i is high, and the next item is not taken until then.
// Reset clears all valid marks and the control state; key and value memories
// are not cleared, and their contents are not used while their valid mark is clear.
module cuckoo_hash_table_top
  import cht_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  in_cmd_i,
  input  logic [31:0] in_key_i,
  input  logic signed [31:0] in_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  out_status_o,
  output logic signed [31:0] out_found_value_o
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SRead   = 4'd1;
  localparam logic [3:0] SDecide = 4'd2;
  localparam logic [3:0] SWalkRd = 4'd3;
  localparam logic [3:0] SWalk   = 4'd4;
  localparam logic [3:0] SMovRd  = 4'd5;
  localparam logic [3:0] SMove   = 4'd6;
  localparam logic [3:0] SPlace  = 4'd7;
  localparam logic [3:0] SOut    = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] cmd_q;
  logic [31:0] key_q, val_q;
  logic [FirstDepth-1:0]  v1_q, v1_d;
  logic [SecondDepth-1:0] v2_q, v2_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic tbl_q, tbl_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [2:0] status_q, status_d;
  logic [31:0] fv_q, fv_d;

  logic [SlotW-1:0] path_q [PathLimit];
  logic path_we;
  logic [PathAw-1:0] path_wa;

  logic we1, we2;
  logic [FirstAw-1:0] wa1, ra1;
  logic [SecondAw-1:0] wa2, ra2;
  logic [63:0] wd1, wd2, rd1, rd2;
  entry_t e1, e2;

  cht_mem #(.Depth(FirstDepth), .Aw(FirstAw)) u_mem1 (
    .clk_i, .we_i(we1), .waddr_i(wa1), .wdata_i(wd1), .raddr_i(ra1), .rdata_o(rd1)
  );
  cht_mem #(.Depth(SecondDepth), .Aw(SecondAw)) u_mem2 (
    .clk_i, .we_i(we2), .waddr_i(wa2), .wdata_i(wd2), .raddr_i(ra2), .rdata_o(rd2)
  );

  assign e1 = rd1;
  assign e2 = rd2;

  logic [FirstAw-1:0]  ha, ha_in;
  logic [SecondAw-1:0] hb, hb_in;
  logic hit1, hit2;
  logic [SlotW-1:0] pslot;

  assign ha    = key_q[FirstAw-1:0];
  assign hb    = key_q[SecondAw-1:0];
  assign ha_in = in_key_i[FirstAw-1:0];
  assign hb_in = in_key_i[SecondAw-1:0];
  assign hit1  = v1_q[ha] && (e1.key == key_q);
  assign hit2  = v2_q[hb] && (e2.key == key_q);
  assign pslot = path_q[path_wa];

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_q[path_wa] <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      v1_q     <= '0;
      v2_q     <= '0;
      depth_q  <= '0;
      tbl_q    <= 1'b0;
      idx_q    <= '0;
      status_q <= StNotFound;
      fv_q     <= '0;
    end else begin
      state_q  <= state_d;
      v1_q     <= v1_d;
      v2_q     <= v2_d;
      depth_q  <= depth_d;
      tbl_q    <= tbl_d;
      idx_q    <= idx_d;
      status_q <= status_d;
      fv_q     <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      cmd_q <= in_cmd_i;
      key_q <= in_key_i;
      val_q <= in_value_i;
    end
  end

  always_comb begin
    state_d  = state_q;
    v1_d     = v1_q;
    v2_d     = v2_q;
    depth_d  = depth_q;
    tbl_d    = tbl_q;
    idx_d    = idx_q;
    status_d = status_q;
    fv_d     = fv_q;
    we1      = 1'b0;
    we2      = 1'b0;
    wa1      = ha;
    wa2      = hb;
    wd1      = {key_q, val_q};
    wd2      = {key_q, val_q};
    ra1      = ha;
    ra2      = hb;
    path_we  = 1'b0;
    path_wa  = depth_q[PathAw-1:0];
    unique case (state_q)
      SIdle: begin
        ra1 = ha_in;
        ra2 = hb_in;
        if (in_valid_i) begin
          state_d = SDecide;
        end
      end
      SRead: begin
        state_d = SDecide;
      end
      SDecide: begin
        status_d = StNotFound;
        fv_d     = '0;
        state_d  = SOut;
        unique case (cmd_q)
          CmdSearch: begin
            if (hit1) begin
              status_d = StFound;
              fv_d     = e1.value;
            end else if (hit2) begin
              status_d = StFound;
              fv_d     = e2.value;
            end
          end
          CmdInsert: begin
            if (hit1) begin
              we1      = 1'b1;
              wd1      = {e1.key, val_q};
              status_d = StUpdated;
            end else if (hit2) begin
              we2      = 1'b1;
              wd2      = {e2.key, val_q};
              status_d = StUpdated;
            end else if (!v1_q[ha] || !v2_q[hb]) begin
              state_d = SPlace;
            end else begin
              depth_d = '0;
              tbl_d   = 1'b0;
              idx_d   = SlotW'(ha);
              state_d = SWalk;
            end
          end
          CmdRemove: begin
            if (hit1) begin
              v1_d[ha] = 1'b0;
              status_d = StRemoved;
            end else if (hit2) begin
              v2_d[hb] = 1'b0;
              status_d = StRemoved;
            end
          end
          default: ;
        endcase
      end
      SWalkRd: begin
        ra1 = idx_q[FirstAw-1:0];
        ra2 = idx_q[SecondAw-1:0];
        state_d = SWalk;
      end
      SWalk: begin
        // idx_q names the current slot; its entry is on rd1 or rd2 (as tbl_q selects) at every depth.
        ra1 = idx_q[FirstAw-1:0];
        ra2 = idx_q[SecondAw-1:0];
        if (depth_q == DepthW'(PathLimit)) begin
          status_d = StFull;
          fv_d     = '0;
          state_d  = SOut;
        end else if (!(tbl_q ? v2_q[idx_q[SecondAw-1:0]] : v1_q[idx_q[FirstAw-1:0]])) begin
          state_d = SMovRd;
        end else begin
          state_d = SWalkRd;
          path_we = 1'b1;
          depth_d = depth_q + 1'b1;
          tbl_d   = ~tbl_q;
          idx_d   = tbl_q ? SlotW'(e2.key[FirstAw-1:0]) : SlotW'(e1.key[SecondAw-1:0]);
        end
      end
      SMovRd: begin
        if (depth_q == '0) begin
          state_d = SPlace;
        end else begin
          path_wa = PathAw'(depth_q - 1'b1);
          ra1     = pslot[FirstAw-1:0];
          ra2     = pslot[SecondAw-1:0];
          state_d = SMove;
        end
      end
      SMove: begin
        path_wa = PathAw'(depth_q - 1'b1);
        depth_d = depth_q - 1'b1;
        if (!depth_d[0]) begin
          wa2 = e1.key[SecondAw-1:0];
          wd2 = e1;
          we2 = 1'b1;
          v2_d[e1.key[SecondAw-1:0]] = 1'b1;
          v1_d[pslot[FirstAw-1:0]]   = 1'b0;
        end else begin
          wa1 = e2.key[FirstAw-1:0];
          wd1 = e2;
          we1 = 1'b1;
          v1_d[e2.key[FirstAw-1:0]]  = 1'b1;
          v2_d[pslot[SecondAw-1:0]]  = 1'b0;
        end
        state_d = SMovRd;
      end
      SPlace: begin
        if (v1_q[ha] || !v2_q[hb]) begin
          we2 = 1'b1;
          v2_d[hb] = 1'b1;
        end else begin
          we1 = 1'b1;
          v1_d[ha] = 1'b1;
        end
        status_d = StInserted;
        fv_d     = '0;
        state_d  = SOut;
      end
      SOut: begin
        if (!out_stall_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign in_stall_o        = (state_q != SIdle);
  assign out_valid_o       = (state_q == SOut);
  assign out_status_o      = status_q;
  assign out_found_value_o = fv_q;

  a_one_hot_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(we1 && we2)) else $error("both tables written at once");
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o))
    else $error("result dropped under stall");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(PathLimit)) else $error("path depth overrun");

endmodule
